/* src/pwm_pkg.sv */
// Shared constants, register codes and word types for the perspective warp map generator.
package pwm_pkg;

  // Format of coordinates and of the sub-pixel position
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 5;
  localparam int MARGIN_PX  = 5;

  // Datapath widths, some derived from the formats above
  localparam int COEF_W = 32;
  localparam int PROD_W = COEF_W + COORD_BITS + 1;   // signed coef times unsigned coord
  localparam int SUM_W  = PROD_W + 2;                // two products plus a constant
  localparam int MAG_W  = SUM_W;                     // magnitude of a sum
  localparam int DIV_W  = MAG_W + FRAC_BITS;         // scaled numerator magnitude
  localparam int Q_W    = 33;                        // quotient bits resolved by the divider
  localparam int POS_W  = 32;                        // clamped position width
  localparam int SIZE_W = 13;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 4;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 4'd0,
    REG_FRAME_HEIGHT = 4'd1,
    REG_ROW0_XY      = 4'd2,
    REG_ROW0_C       = 4'd3,
    REG_ROW1_XY      = 4'd4,
    REG_ROW1_C       = 4'd5,
    REG_ROW2_XY      = 4'd6,
    REG_ROW2_C       = 4'd7
  } cfg_reg_t;

  // Register file contents
  typedef struct packed {
    logic [SIZE_W-1:0] frame_width;
    logic [SIZE_W-1:0] frame_height;
    logic [63:0]       row0_xy;
    logic [31:0]       row0_c;
    logic [63:0]       row1_xy;
    logic [31:0]       row1_c;
    logic [63:0]       row2_xy;
    logic [31:0]       row2_c;
  } cfg_t;

  // Word from front to back: numerators and denominator
  typedef struct packed {
    logic signed [SUM_W-1:0] nx;
    logic signed [SUM_W-1:0] ny;
    logic signed [SUM_W-1:0] w;
  } dot_word_t;

  // Queue status toward the front
  typedef struct packed {
    logic [QCNT_W-1:0] count;
  } queue_stat_t;

endpackage

/* src/pwm_front.sv */
// Front: takes a destination pixel and forms the two numerators and the denominator.
module pwm_front (
  input  logic                            clk,
  input  logic                            rst,
  input  pwm_pkg::cfg_t                   cfg,
  input  logic                            fire,
  input  logic [pwm_pkg::COORD_BITS-1:0]  col,
  input  logic [pwm_pkg::COORD_BITS-1:0]  row,
  output logic                            push,
  output pwm_pkg::dot_word_t              push_word,
  output logic [1:0]                      inflight
);

  logic signed [pwm_pkg::COORD_BITS:0] col_s, row_s;
  logic signed [pwm_pkg::PROD_W-1:0]   pr [0:5];
  logic signed [pwm_pkg::COEF_W-1:0]   cst [0:2];
  logic                                v1, v2;

  assign col_s = signed'({1'b0, col});
  assign row_s = signed'({1'b0, row});

  // Stage 1: six products, constants carried along
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= fire;
    pr[0] <= signed'(cfg.row0_xy[63:32]) * col_s;
    pr[1] <= signed'(cfg.row0_xy[31:0])  * row_s;
    pr[2] <= signed'(cfg.row1_xy[63:32]) * col_s;
    pr[3] <= signed'(cfg.row1_xy[31:0])  * row_s;
    pr[4] <= signed'(cfg.row2_xy[63:32]) * col_s;
    pr[5] <= signed'(cfg.row2_xy[31:0])  * row_s;
    cst[0] <= signed'(cfg.row0_c);
    cst[1] <= signed'(cfg.row1_c);
    cst[2] <= signed'(cfg.row2_c);
  end

  // Stage 2: dot products
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    push_word.nx <= pwm_pkg::SUM_W'(pr[0]) + pwm_pkg::SUM_W'(pr[1])
                    + pwm_pkg::SUM_W'(cst[0]);
    push_word.ny <= pwm_pkg::SUM_W'(pr[2]) + pwm_pkg::SUM_W'(pr[3])
                    + pwm_pkg::SUM_W'(cst[1]);
    push_word.w  <= pwm_pkg::SUM_W'(pr[4]) + pwm_pkg::SUM_W'(pr[5])
                    + pwm_pkg::SUM_W'(cst[2]);
  end

  assign push     = v2;
  assign inflight = {1'b0, v1} + {1'b0, v2};

endmodule

/* src/pwm_queue.sv */
// Short queue of dot-product words between front and back.
module pwm_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  pwm_pkg::dot_word_t    push_word,
  input  logic                  pop,
  output logic                  not_empty,
  output pwm_pkg::dot_word_t    head,
  output pwm_pkg::queue_stat_t  stat
);

  pwm_pkg::dot_word_t            mem [0:pwm_pkg::QDEPTH-1];
  logic [pwm_pkg::QPTR_W-1:0]    wr_ptr, rd_ptr;
  logic [pwm_pkg::QCNT_W-1:0]    count;

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_word;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  assign not_empty  = (count != '0);
  assign head       = mem[rd_ptr];
  assign stat.count = count;

endmodule

/* src/pwm_back.sv */
// Back: pipelined rounding division, clamping, and result formatting with output register.
module pwm_back (
  input  logic                clk,
  input  logic                rst,
  input  pwm_pkg::cfg_t       cfg,
  input  logic                q_not_empty,
  input  pwm_pkg::dot_word_t  q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  src_col_int,
  output logic signed [15:0]  src_row_int,
  output logic [9:0]          frac_index,
  output logic                inside_margin
);

  localparam int NS = pwm_pkg::Q_W;
  localparam int DW = pwm_pkg::DIV_W;
  localparam int MW = pwm_pkg::MAG_W;
  localparam int PW = pwm_pkg::POS_W;
  localparam int FB = pwm_pkg::FRAC_BITS;

  logic adv;

  // Whole back pipeline moves when the output register can take a word
  assign adv   = !out_valid || out_ready;
  assign q_pop = adv && q_not_empty;

  // Divider stage registers; index 0 is the setup stage
  logic          v    [0:NS];
  logic [DW-1:0] remx [0:NS];
  logic [DW-1:0] remy [0:NS];
  logic [NS-1:0] qx   [0:NS];
  logic [NS-1:0] qy   [0:NS];
  logic [MW-1:0] uw   [0:NS];
  logic          negx [0:NS];
  logic          negy [0:NS];
  logic          ovx  [0:NS];
  logic          ovy  [0:NS];
  logic          zw   [0:NS];

  // Setup: magnitudes, signs, zero denominator and quotient overflow
  logic [MW-1:0] unx_m, uny_m, uw_m;
  logic [DW-1:0] unx_s, uny_s, uw_x;
  assign unx_m = q_head.nx[MW-1] ? MW'(-q_head.nx) : MW'(q_head.nx);
  assign uny_m = q_head.ny[MW-1] ? MW'(-q_head.ny) : MW'(q_head.ny);
  assign uw_m  = q_head.w[MW-1]  ? MW'(-q_head.w)  : MW'(q_head.w);
  assign unx_s = {unx_m, {FB{1'b0}}};
  assign uny_s = {uny_m, {FB{1'b0}}};
  assign uw_x  = DW'(uw_m);

  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else if (adv) v[0] <= q_pop;
    if (adv) begin
      remx[0] <= unx_s;
      remy[0] <= uny_s;
      qx[0]   <= '0;
      qy[0]   <= '0;
      uw[0]   <= uw_m;
      negx[0] <= q_head.nx[MW-1] ^ q_head.w[MW-1];
      negy[0] <= q_head.ny[MW-1] ^ q_head.w[MW-1];
      ovx[0]  <= (unx_s >> NS) >= uw_x;
      ovy[0]  <= (uny_s >> NS) >= uw_x;
      zw[0]   <= (uw_m == '0);
    end
  end

  // Restoring division, one quotient bit per stage, most significant first
  for (genvar s = 1; s <= NS; s++) begin : g_div
    localparam int K = NS - s;
    logic [DW-1:0] dsh;
    logic          gex, gey;
    assign dsh = DW'(uw[s-1]) << K;
    assign gex = (remx[s-1] >> K) >= DW'(uw[s-1]);
    assign gey = (remy[s-1] >> K) >= DW'(uw[s-1]);
    always_ff @(posedge clk) begin
      if (rst) v[s] <= 1'b0;
      else if (adv) v[s] <= v[s-1];
      if (adv) begin
        remx[s] <= gex ? remx[s-1] - dsh : remx[s-1];
        remy[s] <= gey ? remy[s-1] - dsh : remy[s-1];
        qx[s]   <= {qx[s-1][NS-2:0], gex};
        qy[s]   <= {qy[s-1][NS-2:0], gey};
        uw[s]   <= uw[s-1];
        negx[s] <= negx[s-1];
        negy[s] <= negy[s-1];
        ovx[s]  <= ovx[s-1];
        ovy[s]  <= ovy[s-1];
        zw[s]   <= zw[s-1];
      end
    end
  end

  // Round to nearest, ties to even, and clamp the magnitude to 2^31
  logic [MW:0]   r2x, r2y, uwe;
  logic          incx, incy;
  logic [NS:0]   qrx, qry;
  logic [PW-1:0] mag_lim;
  logic          v_r1, nx_r1, ny_r1;
  logic [PW-1:0] magx, magy;

  assign mag_lim = {1'b1, {(PW-1){1'b0}}};
  assign uwe  = {1'b0, uw[NS]};
  assign r2x  = {remx[NS][MW-1:0], 1'b0};
  assign r2y  = {remy[NS][MW-1:0], 1'b0};
  assign incx = (r2x > uwe) || ((r2x == uwe) && qx[NS][0]);
  assign incy = (r2y > uwe) || ((r2y == uwe) && qy[NS][0]);
  assign qrx  = {1'b0, qx[NS]} + (NS+1)'(incx);
  assign qry  = {1'b0, qy[NS]} + (NS+1)'(incy);

  always_ff @(posedge clk) begin
    if (rst) v_r1 <= 1'b0;
    else if (adv) v_r1 <= v[NS];
    if (adv) begin
      nx_r1 <= negx[NS];
      ny_r1 <= negy[NS];
      if (zw[NS]) magx <= '0;
      else if (ovx[NS] || qrx > (NS+1)'(mag_lim)) magx <= mag_lim;
      else magx <= qrx[PW-1:0];
      if (zw[NS]) magy <= '0;
      else if (ovy[NS] || qry > (NS+1)'(mag_lim)) magy <= mag_lim;
      else magy <= qry[PW-1:0];
    end
  end

  // Apply sign; a positive full-scale magnitude saturates to the largest int
  logic              v_r2;
  logic signed [PW-1:0] px, py;

  always_ff @(posedge clk) begin
    if (rst) v_r2 <= 1'b0;
    else if (adv) v_r2 <= v_r1;
    if (adv) begin
      if (nx_r1)        px <= signed'(-magx);
      else if (magx[PW-1]) px <= signed'({1'b0, {(PW-1){1'b1}}});
      else              px <= signed'(magx);
      if (ny_r1)        py <= signed'(-magy);
      else if (magy[PW-1]) py <= signed'({1'b0, {(PW-1){1'b1}}});
      else              py <= signed'(magy);
    end
  end

  // Integer part (floor), saturated to 16 bits
  localparam int IW = PW - FB;
  logic signed [IW-1:0] ix, iy;
  logic signed [15:0]   sx, sy;
  assign ix = IW'(px >>> FB);
  assign iy = IW'(py >>> FB);
  assign sx = (ix > IW'(32767)) ? 16'sh7fff : (ix < -IW'(32768)) ? -16'sh8000 : ix[15:0];
  assign sy = (iy > IW'(32767)) ? 16'sh7fff : (iy < -IW'(32768)) ? -16'sh8000 : iy[15:0];

  // Margin test against the frame, using the rounded position
  localparam int HW = PW + 2;
  logic signed [HW-1:0] lo, hix, hiy, pxe, pye;
  logic                 in_m;
  assign lo  = HW'(pwm_pkg::MARGIN_PX) <<< FB;
  assign hix = (HW'(signed'({1'b0, cfg.frame_width}))  - HW'(pwm_pkg::MARGIN_PX + 1)) <<< FB;
  assign hiy = (HW'(signed'({1'b0, cfg.frame_height})) - HW'(pwm_pkg::MARGIN_PX + 1)) <<< FB;
  assign pxe = HW'(px);
  assign pye = HW'(py);
  assign in_m = (pxe > lo) && (pxe < hix) && (pye > lo) && (pye < hiy);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= v_r2;
    if (adv) begin
      src_col_int   <= sx;
      src_row_int   <= sy;
      frac_index    <= 10'({py[FB-1:0], px[FB-1:0]});
      inside_margin <= in_m;
    end
  end

endmodule

/* src/perspective_warp_map_generator_core.sv */
// Order: front, queue, setup, divider (one quotient bit per stage), round, sign, output.
// Throughput: one pixel per cycle, set by the fully pipelined divider; the back pipeline
// stalls as a whole on output backpressure, and a 4-word queue decouples the front.
// Reset (synchronous, active high) clears all valids and the queue, and loads the
// registers with 640x480 frame and the identity matrix; no clearing pass is needed.
module perspective_warp_map_generator_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [11:0]                       dest_col,
  input  logic [11:0]                       dest_row,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [15:0]                src_col_int,
  output logic signed [15:0]                src_row_int,
  output logic [9:0]                        frac_index,
  output logic                              inside_margin,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pwm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [63:0]                       cfg_data
);

  pwm_pkg::cfg_t        cfg;
  pwm_pkg::dot_word_t   push_word, head;
  pwm_pkg::queue_stat_t qstat;
  logic                 push, pop, not_empty, in_fire;
  logic [1:0]           inflight;

  // Register file
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= 13'd640;
      cfg.frame_height <= 13'd480;
      cfg.row0_xy      <= 64'h0001_0000_0000_0000;
      cfg.row0_c       <= '0;
      cfg.row1_xy      <= 64'h0000_0000_0001_0000;
      cfg.row1_c       <= '0;
      cfg.row2_xy      <= '0;
      cfg.row2_c       <= 32'h0001_0000;
    end else if (cfg_valid) begin
      case (cfg_index)
        pwm_pkg::REG_FRAME_WIDTH:  cfg.frame_width  <= cfg_data[pwm_pkg::SIZE_W-1:0];
        pwm_pkg::REG_FRAME_HEIGHT: cfg.frame_height <= cfg_data[pwm_pkg::SIZE_W-1:0];
        pwm_pkg::REG_ROW0_XY:      cfg.row0_xy      <= cfg_data;
        pwm_pkg::REG_ROW0_C:       cfg.row0_c       <= cfg_data[31:0];
        pwm_pkg::REG_ROW1_XY:      cfg.row1_xy      <= cfg_data;
        pwm_pkg::REG_ROW1_C:       cfg.row1_c       <= cfg_data[31:0];
        pwm_pkg::REG_ROW2_XY:      cfg.row2_xy      <= cfg_data;
        pwm_pkg::REG_ROW2_C:       cfg.row2_c       <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Credit check: queue words plus words still in the front must fit the queue
  assign in_ready = (pwm_pkg::QCNT_W'(qstat.count) + pwm_pkg::QCNT_W'(inflight))
                    < pwm_pkg::QCNT_W'(pwm_pkg::QDEPTH);
  assign in_fire  = in_valid && in_ready;

  pwm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .fire      (in_fire),
    .col       (dest_col[pwm_pkg::COORD_BITS-1:0]),
    .row       (dest_row[pwm_pkg::COORD_BITS-1:0]),
    .push      (push),
    .push_word (push_word),
    .inflight  (inflight)
  );

  pwm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head),
    .stat      (qstat)
  );

  pwm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_not_empty   (not_empty),
    .q_head        (head),
    .q_pop         (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .src_col_int   (src_col_int),
    .src_row_int   (src_row_int),
    .frac_index    (frac_index),
    .inside_margin (inside_margin)
  );

endmodule

/* tb/sv/tb_perspective_warp_map_generator_core.sv */
// Self-checking testbench for the perspective warp map generator core.
module tb_perspective_warp_map_generator_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [pwm_pkg::CFG_IDX_W-1:0] UNMAPPED_REG = 4'd9;
  localparam longint Q16_ONE = 65536;
  localparam int PIXEL_LATENCY = 45;

  // Expected output word of one pixel
  typedef struct {
    logic signed [15:0] col_int;
    logic signed [15:0] row_int;
    logic [9:0]         frac;
    logic               in_margin;
  } warp_word_t;

  // Warp predictor plus queue of pending source positions
  class warp_scoreboard;
    logic [12:0] width, height;
    logic [63:0] r0_xy, r1_xy, r2_xy;
    logic [31:0] r0_c, r1_c, r2_c;
    warp_word_t  pending_q[$];
    int          mismatches;

    function void load_reset();
      width = 640; height = 480;
      r0_xy = 64'(Q16_ONE) << 32; r0_c = 0;
      r1_xy = 64'(Q16_ONE);       r1_c = 0;
      r2_xy = 0;                  r2_c = 32'(Q16_ONE);
    endfunction

    function void write_reg(logic [pwm_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
      case (idx)
        pwm_pkg::REG_FRAME_WIDTH:  width  = data[12:0];
        pwm_pkg::REG_FRAME_HEIGHT: height = data[12:0];
        pwm_pkg::REG_ROW0_XY:      r0_xy  = data;
        pwm_pkg::REG_ROW0_C:       r0_c   = data[31:0];
        pwm_pkg::REG_ROW1_XY:      r1_xy  = data;
        pwm_pkg::REG_ROW1_C:       r1_c   = data[31:0];
        pwm_pkg::REG_ROW2_XY:      r2_xy  = data;
        pwm_pkg::REG_ROW2_C:       r2_c   = data[31:0];
        default: ;
      endcase
    endfunction

    function longint dot(logic [63:0] xy, logic [31:0] c, longint col, longint row);
      longint a, b, k;
      a = longint'($signed(xy[63:32]));
      b = longint'($signed(xy[31:0]));
      k = longint'($signed(c));
      return a * col + b * row + k;
    endfunction

    // round(32*n/w) ties to even, clamped to int32; zero denominator gives 0
    function longint project(longint n, longint w);
      longint unsigned un, uw, q, r;
      bit neg;
      if (w == 0) return 0;
      un = (n < 0) ? longint'(-n) : n;
      uw = (w < 0) ? longint'(-w) : w;
      neg = (n < 0) != (w < 0);
      un = un << pwm_pkg::FRAC_BITS;
      q = un / uw;
      r = un % uw;
      if (r > uw - r || (r == uw - r && q[0])) q++;
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      if (neg) return -longint'(q);
      return (q > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : longint'(q);
    endfunction

    function logic signed [15:0] whole(longint p);
      longint v;
      v = p >>> pwm_pkg::FRAC_BITS;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
    endfunction

    function bit in_frame(longint p, logic [12:0] size);
      longint hi;
      hi = (longint'(size) - 1 - pwm_pkg::MARGIN_PX) * (1 << pwm_pkg::FRAC_BITS);
      return p > pwm_pkg::MARGIN_PX * (1 << pwm_pkg::FRAC_BITS) && p < hi;
    endfunction

    function void note_pixel(logic [11:0] c, logic [11:0] r);
      longint px, py, w;
      warp_word_t e;
      w  = dot(r2_xy, r2_c, c, r);
      px = project(dot(r0_xy, r0_c, c, r), w);
      py = project(dot(r1_xy, r1_c, c, r), w);
      e.col_int   = whole(px);
      e.row_int   = whole(py);
      e.frac      = {py[4:0], px[4:0]};
      e.in_margin = in_frame(px, width) && in_frame(py, height);
      pending_q.insert(pending_q.size(), e);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_result(warp_word_t got);
      warp_word_t e;
      if (pending_q.size() == 0) begin
        report("output word with nothing pending");
        return;
      end
      e = pending_q.pop_front();
      if (got.col_int !== e.col_int)
        report($sformatf("src_col_int %0d, want %0d", got.col_int, e.col_int));
      if (got.row_int !== e.row_int)
        report($sformatf("src_row_int %0d, want %0d", got.row_int, e.row_int));
      if (got.frac !== e.frac)
        report($sformatf("frac_index %0d, want %0d", got.frac, e.frac));
      if (got.in_margin !== e.in_margin)
        report($sformatf("inside_margin %0b, want %0b", got.in_margin, e.in_margin));
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready;
  logic [11:0] dest_col = 0, dest_row = 0;
  logic out_valid, out_ready = 0;
  logic signed [15:0] src_col_int, src_row_int;
  logic [9:0] frac_index;
  logic inside_margin;
  logic cfg_valid = 0, cfg_ready;
  logic [pwm_pkg::CFG_IDX_W-1:0] cfg_index = 0;
  logic [63:0] cfg_data = 0;

  warp_scoreboard sb = new();
  int send_idle_pct = 0, recv_stall_pct = 0, hold_left = 0;

  perspective_warp_map_generator_core DUT (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Receiver ready: random stalls plus an optional long hold-off
  always begin
    @(negedge clk);
    if (hold_left > 0) begin
      out_ready <= 0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    warp_word_t got;
    if (!rst && out_valid && out_ready) begin
      got.col_int   = src_col_int;
      got.row_int   = src_row_int;
      got.frac      = frac_index;
      got.in_margin = inside_margin;
      sb.check_result(got);
    end
  end

  task automatic send_pixel(logic [11:0] c, logic [11:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    dest_col <= c;
    dest_row <= r;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(c, r);
    @(negedge clk);
  endtask

  // One register write, then cfg_valid is dropped on the config channel before returning
  task automatic write_cfg(logic [pwm_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  // Wait until every pending word has arrived, then let the pipe settle
  task automatic drain();
    in_valid <= 0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (PIXEL_LATENCY) @(negedge clk);
  endtask

  task automatic write_matrix(logic [31:0] m[9]);
    write_cfg(pwm_pkg::REG_ROW0_XY, {m[0], m[1]});
    write_cfg(pwm_pkg::REG_ROW0_C, {$urandom(), m[2]});
    write_cfg(pwm_pkg::REG_ROW1_XY, {m[3], m[4]});
    write_cfg(pwm_pkg::REG_ROW1_C, {$urandom(), m[5]});
    write_cfg(pwm_pkg::REG_ROW2_XY, {m[6], m[7]});
    write_cfg(pwm_pkg::REG_ROW2_C, {$urandom(), m[8]});
  endtask

  function automatic logic [12:0] pick_size();
    case ($urandom_range(7))
      0: return 0;
      1: return 1;
      2: return 12;
      3: return 4096;
      4: return 8191;
      default: return 13'($urandom_range(4096, 1));
    endcase
  endfunction

  function automatic logic [31:0] rnd_q16(int mag);
    return 32'($signed($urandom_range(2 * mag)) - mag);
  endfunction

  function automatic logic [11:0] pick_coord();
    case ($urandom_range(9))
      0: return 0;
      1: return 12'hFFF;
      default: return 12'($urandom());
    endcase
  endfunction

  initial begin
    logic [31:0] m[9];
    int kind;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    sb.load_reset();

    // Identity matrix at reset: corners and the margin edges
    send_pixel(0, 0);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(5, 5);
    send_pixel(6, 6);
    send_pixel(633, 473);
    send_pixel(634, 474);
    send_pixel(12'hAAA, 12'h555);
    drain();

    // Scale by 1/64 with a negated x: exact halves, ties to even
    m = '{32'hFFFF_0000, 0, 0, 0, 32'(Q16_ONE), 0, 0, 0, 32'(64 * Q16_ONE)};
    write_matrix(m);
    write_cfg(pwm_pkg::REG_FRAME_WIDTH, 64'hFFFF_E000 | 13'd7);
    write_cfg(pwm_pkg::REG_FRAME_HEIGHT, 0);
    send_pixel(1, 1);
    send_pixel(3, 3);
    send_pixel(5, 2);
    send_pixel(7, 9);
    drain();

    // Zero denominator, then a write to an unmapped index
    m = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
          32'h8000_0000, 0, 0, 0};
    write_matrix(m);
    write_cfg(UNMAPPED_REG, 64'h1);
    send_pixel(12'hFFF, 0);
    send_pixel(100, 200);
    drain();

    // Tiny denominator: huge quotients saturate both ways
    m[8] = 1;
    write_cfg(pwm_pkg::REG_ROW2_C, 64'(m[8]));
    send_pixel(12'hFFF, 1);
    send_pixel(0, 12'hFFF);
    send_pixel(0, 0);
    drain();

    // Random phases with fresh matrices and frame sizes
    for (int ph = 0; ph < 12; ph++) begin
      kind = $urandom_range(3);
      for (int i = 0; i < 9; i++) m[i] = $urandom();
      if (kind == 1 || kind == 2) begin
        m[0] = rnd_q16(4 * 65536); m[1] = rnd_q16(65536);
        m[3] = rnd_q16(65536);     m[4] = rnd_q16(4 * 65536);
        m[2] = rnd_q16(1 << 28);   m[5] = rnd_q16(1 << 28);
        m[6] = (kind == 2) ? rnd_q16(256) : 0;
        m[7] = (kind == 2) ? rnd_q16(256) : 0;
        m[8] = 32'($urandom_range(3 * 65536, 16384));
      end else if (kind == 3) begin
        m[6] = rnd_q16(8); m[7] = rnd_q16(8); m[8] = rnd_q16(8);
      end
      write_matrix(m);
      write_cfg(pwm_pkg::REG_FRAME_WIDTH, {$urandom(), $urandom()} & ~64'h1FFF | pick_size());
      write_cfg(pwm_pkg::REG_FRAME_HEIGHT, 64'(pick_size()));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      if (ph == 4) begin
        send_idle_pct = 0;
        hold_left = 300;
      end
      for (int i = 0; i < 100; i++) send_pixel(pick_coord(), pick_coord());
      drain();
    end

    if (sb.pending_q.size() != 0) sb.report("pixels left without output");
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* perspective_warp_map_generator_core.f */
src/pwm_pkg.sv
src/pwm_front.sv
src/pwm_queue.sv
src/pwm_back.sv
src/perspective_warp_map_generator_core.sv
tb/sv/tb_perspective_warp_map_generator_core.sv
